// ===== src/ole_pkg.sv =====
// ole_pkg: shared types and constants of the ordered list engine.
// Used by ole_ctrl and ordered_list_engine_top; no dependencies.
`default_nettype none

package ole_pkg;

    localparam int DEPTH = 16;
    localparam int WIDTH = 32;

    localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW   = $clog2(DEPTH + 1);
    localparam int CMPW = 8;

    localparam int CMD_W  = 4;
    localparam int VAL_W  = 32;
    localparam int POS_W  = 5;
    localparam int STAT_W = 3;
    localparam int IDX_W  = 4;
    localparam int CNT_W  = 5;

    typedef enum logic [CMD_W-1:0] {
        CMD_PUSH_BACK  = 4'd0,
        CMD_POP_BACK   = 4'd1,
        CMD_PUSH_FRONT = 4'd2,
        CMD_POP_FRONT  = 4'd3,
        CMD_FIND       = 4'd4,
        CMD_INSERT     = 4'd5,
        CMD_ERASE      = 4'd6,
        CMD_REMOVE     = 4'd7,
        CMD_REMOVE_ALL = 4'd8,
        CMD_DUMP       = 4'd9
    } t_cmd;

    localparam logic [STAT_W-1:0] STAT_OK       = 3'd0;
    localparam logic [STAT_W-1:0] STAT_FULL     = 3'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY    = 3'd2;
    localparam logic [STAT_W-1:0] STAT_NOTFOUND = 3'd3;
    localparam logic [STAT_W-1:0] STAT_BADPOS   = 3'd4;

    typedef enum logic {
        S_IDLE,
        S_WALK
    } t_state;

    typedef enum logic [2:0] {
        M_SHUP,
        M_SHDN,
        M_FIND,
        M_COMPACT,
        M_DUMP
    } t_mode;

    typedef struct packed {
        logic             we;
        logic [IW-1:0]    waddr;
        logic [WIDTH-1:0] wdata;
        logic             re;
        logic [IW-1:0]    raddr;
    } t_ram_req;

endpackage

`default_nettype wire

// ===== src/ordered_list_engine_top.sv =====
// push_back, pop_back and rejected commands give their result in the cycle after
// the item; a walk gives its result once it has read the entries it needs, remove
// walks a second time when it finds a match, and dump gives each entry in order.
// Throughput: one item at a time; the walk reads one store entry per cycle through
// a single RAM read port; the next item may start with the final result. Reset
// (i_rst_n low, synchronous): count cleared, sequencer idle, store contents
// undefined and never cleared; results cannot be stalled.
`default_nettype none

module ordered_list_engine_top (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ole_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [ole_pkg::VAL_W-1:0]     i_value,
    input  wire logic [ole_pkg::POS_W-1:0]     i_position,
    output logic                               o_strobe,
    output logic [ole_pkg::STAT_W-1:0]         o_status,
    output logic [ole_pkg::IDX_W-1:0]          o_found_index,
    output logic [ole_pkg::VAL_W-1:0]          o_entry_value,
    output logic [ole_pkg::CNT_W-1:0]          o_entry_count,
    output logic                               o_last
);

    ole_pkg::t_ram_req             ram_req;
    logic [ole_pkg::WIDTH-1:0]     ram_rdata;

    ole_ram #(
        .W (ole_pkg::WIDTH),
        .D (ole_pkg::DEPTH)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (ram_req.we),
        .i_waddr (ram_req.waddr),
        .i_wdata (ram_req.wdata),
        .i_re    (ram_req.re),
        .i_raddr (ram_req.raddr),
        .o_rdata (ram_rdata)
    );

    ole_ctrl u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_ram_req     (ram_req),
        .i_ram_rdata   (ram_rdata),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_value (o_entry_value),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (int'(o_entry_count) <= ole_pkg::DEPTH))
        else $error("entry count above depth");

    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last) |-> !busy)
        else $error("final result while sequencer still busy");

    a_dump_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last) |-> (busy && (o_status == ole_pkg::STAT_OK)))
        else $error("partial result outside dump");

    a_full_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && (o_status == ole_pkg::STAT_FULL))
            |-> (int'(o_entry_count) == ole_pkg::DEPTH))
        else $error("full reported below depth");
`endif

endmodule

`default_nettype wire

// ===== src/ole_ram.sv =====
// ole_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module ole_ram #(
    parameter int W = 32,
    parameter int D = 16
) (
    input  wire logic                                i_clk,
    input  wire logic                                i_we,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_waddr,
    input  wire logic [W-1:0]                        i_wdata,
    input  wire logic                                i_re,
    input  wire logic [((D > 1) ? $clog2(D) : 1)-1:0] i_raddr,
    output logic      [W-1:0]                        o_rdata
);

    logic [W-1:0] r_mem [D];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

// ===== src/ole_ctrl.sv =====
// ole_ctrl: command sequencer of the ordered list engine; walks the store one
// entry a cycle through a shared compare/address unit. Depends on ole_pkg.
`default_nettype none

module ole_ctrl (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          start,
    output logic                               busy,
    input  wire logic [ole_pkg::CMD_W-1:0]     i_cmd,
    input  wire logic [ole_pkg::VAL_W-1:0]     i_value,
    input  wire logic [ole_pkg::POS_W-1:0]     i_position,
    output ole_pkg::t_ram_req                  o_ram_req,
    input  wire logic [ole_pkg::WIDTH-1:0]     i_ram_rdata,
    output logic                               o_strobe,
    output logic [ole_pkg::STAT_W-1:0]         o_status,
    output logic [ole_pkg::IDX_W-1:0]          o_found_index,
    output logic [ole_pkg::VAL_W-1:0]          o_entry_value,
    output logic [ole_pkg::CNT_W-1:0]          o_entry_count,
    output logic                               o_last
);

    localparam int IW   = ole_pkg::IW;
    localparam int CW   = ole_pkg::CW;
    localparam int CMPW = ole_pkg::CMPW;
    localparam int WD   = ole_pkg::WIDTH;

    ole_pkg::t_state r_state, n_state;
    ole_pkg::t_mode  r_mode, n_mode;

    logic [CW-1:0]   r_count, n_count;
    logic [CW-1:0]   r_rem, n_rem;
    logic [CW-1:0]   r_wp, n_wp;
    logic [CW-1:0]   r_pos, n_pos;
    logic [IW-1:0]   r_ra, n_ra;
    logic [IW-1:0]   r_da, n_da;
    logic            r_dv, n_dv;
    logic            r_found, n_found;
    logic [IW-1:0]   r_fidx, n_fidx;
    logic            r_rm, n_rm;
    logic [WD-1:0]   r_val, n_val;

    logic                          r_strobe, n_strobe;
    logic [ole_pkg::STAT_W-1:0]    r_ostat, n_ostat;
    logic [ole_pkg::IDX_W-1:0]     r_oidx, n_oidx;
    logic [ole_pkg::VAL_W-1:0]     r_oval, n_oval;
    logic                          r_olast, n_olast;

    logic [WD-1:0]   in_val;
    logic [CMPW-1:0] pos_x;
    logic [CMPW-1:0] cnt_x;
    logic            is_full;
    logic            is_empty;

    assign in_val   = WD'($unsigned(i_value));
    assign pos_x    = CMPW'(i_position);
    assign cnt_x    = CMPW'(r_count);
    assign is_full  = (r_count == CW'(ole_pkg::DEPTH));
    assign is_empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ole_pkg::S_IDLE;
            r_count  <= '0;
            r_dv     <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_dv     <= n_dv;
            r_strobe <= n_strobe;
        end
    end

    always_ff @(posedge i_clk) begin
        r_mode  <= n_mode;
        r_rem   <= n_rem;
        r_wp    <= n_wp;
        r_pos   <= n_pos;
        r_ra    <= n_ra;
        r_da    <= n_da;
        r_found <= n_found;
        r_fidx  <= n_fidx;
        r_rm    <= n_rm;
        r_val   <= n_val;
        r_ostat <= n_ostat;
        r_oidx  <= n_oidx;
        r_oval  <= n_oval;
        r_olast <= n_olast;
    end

    always_comb begin
        n_state  = r_state;
        n_mode   = r_mode;
        n_count  = r_count;
        n_rem    = r_rem;
        n_wp     = r_wp;
        n_pos    = r_pos;
        n_ra     = r_ra;
        n_da     = r_da;
        n_dv     = 1'b0;
        n_found  = r_found;
        n_fidx   = r_fidx;
        n_rm     = r_rm;
        n_val    = r_val;
        n_strobe = 1'b0;
        n_ostat  = r_ostat;
        n_oidx   = r_oidx;
        n_oval   = r_oval;
        n_olast  = r_olast;
        o_ram_req = '0;

        unique case (r_state)
            ole_pkg::S_IDLE: begin
                if (start) begin
                    n_val = in_val;
                    n_rm  = 1'b0;
                    n_oidx  = '0;
                    n_oval  = '0;
                    n_olast = 1'b1;
                    n_ostat = ole_pkg::STAT_OK;
                    unique case (ole_pkg::t_cmd'(i_cmd)) inside
                        ole_pkg::CMD_PUSH_BACK: begin
                            n_strobe = 1'b1;
                            if (is_full) begin
                                n_ostat = ole_pkg::STAT_FULL;
                            end else begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = r_count[IW-1:0];
                                o_ram_req.wdata = in_val;
                                n_count = r_count + CW'(1);
                            end
                        end
                        ole_pkg::CMD_POP_BACK: begin
                            n_strobe = 1'b1;
                            if (is_empty) begin
                                n_ostat = ole_pkg::STAT_EMPTY;
                            end else begin
                                n_count = r_count - CW'(1);
                            end
                        end
                        ole_pkg::CMD_PUSH_FRONT, ole_pkg::CMD_INSERT: begin
                            if ((ole_pkg::t_cmd'(i_cmd) == ole_pkg::CMD_INSERT)
                                && (pos_x > cnt_x)) begin
                                n_strobe = 1'b1;
                                n_ostat  = ole_pkg::STAT_BADPOS;
                            end else if (is_full) begin
                                n_strobe = 1'b1;
                                n_ostat  = ole_pkg::STAT_FULL;
                            end else begin
                                n_pos = (ole_pkg::t_cmd'(i_cmd) == ole_pkg::CMD_INSERT)
                                        ? CW'(i_position) : '0;
                                n_mode  = ole_pkg::M_SHUP;
                                n_ra    = IW'(r_count - CW'(1));
                                n_rem   = r_count - n_pos;
                                n_state = ole_pkg::S_WALK;
                            end
                        end
                        ole_pkg::CMD_POP_FRONT, ole_pkg::CMD_ERASE: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_ostat  = ole_pkg::STAT_EMPTY;
                            end else if ((ole_pkg::t_cmd'(i_cmd) == ole_pkg::CMD_ERASE)
                                         && (pos_x >= cnt_x)) begin
                                n_strobe = 1'b1;
                                n_ostat  = ole_pkg::STAT_BADPOS;
                            end else begin
                                n_pos = (ole_pkg::t_cmd'(i_cmd) == ole_pkg::CMD_ERASE)
                                        ? CW'(i_position) : '0;
                                n_mode  = ole_pkg::M_SHDN;
                                n_ra    = IW'(n_pos + CW'(1));
                                n_rem   = r_count - CW'(1) - n_pos;
                                n_state = ole_pkg::S_WALK;
                            end
                        end
                        ole_pkg::CMD_FIND, ole_pkg::CMD_REMOVE: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_ostat  = (ole_pkg::t_cmd'(i_cmd) == ole_pkg::CMD_FIND)
                                           ? ole_pkg::STAT_NOTFOUND
                                           : ole_pkg::STAT_EMPTY;
                            end else begin
                                n_rm    = (ole_pkg::t_cmd'(i_cmd) == ole_pkg::CMD_REMOVE);
                                n_mode  = ole_pkg::M_FIND;
                                n_found = 1'b0;
                                n_ra    = '0;
                                n_rem   = r_count;
                                n_state = ole_pkg::S_WALK;
                            end
                        end
                        ole_pkg::CMD_REMOVE_ALL, ole_pkg::CMD_DUMP: begin
                            if (is_empty) begin
                                n_strobe = 1'b1;
                                n_ostat  = ole_pkg::STAT_EMPTY;
                            end else begin
                                n_mode = (ole_pkg::t_cmd'(i_cmd) == ole_pkg::CMD_DUMP)
                                         ? ole_pkg::M_DUMP : ole_pkg::M_COMPACT;
                                n_wp    = '0;
                                n_ra    = '0;
                                n_rem   = r_count;
                                n_state = ole_pkg::S_WALK;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end

            ole_pkg::S_WALK: begin
                // read issue: one entry per cycle, data back in the next cycle
                if (r_rem != '0) begin
                    o_ram_req.re    = 1'b1;
                    o_ram_req.raddr = r_ra;
                    n_ra  = (r_mode == ole_pkg::M_SHUP) ? r_ra - IW'(1) : r_ra + IW'(1);
                    n_rem = r_rem - CW'(1);
                    n_dv  = 1'b1;
                    n_da  = r_ra;
                end

                if (r_dv) begin
                    case (r_mode)
                        ole_pkg::M_SHUP: begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_da + IW'(1);
                            o_ram_req.wdata = i_ram_rdata;
                        end
                        ole_pkg::M_SHDN: begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_da - IW'(1);
                            o_ram_req.wdata = i_ram_rdata;
                        end
                        ole_pkg::M_FIND: begin
                            if (i_ram_rdata == r_val) begin
                                n_found = 1'b1;
                                n_fidx  = r_da;
                                n_rem   = '0;
                                n_dv    = 1'b0;
                            end
                        end
                        ole_pkg::M_COMPACT: begin
                            if (i_ram_rdata != r_val) begin
                                o_ram_req.we    = 1'b1;
                                o_ram_req.waddr = r_wp[IW-1:0];
                                o_ram_req.wdata = i_ram_rdata;
                                n_wp = r_wp + CW'(1);
                            end
                        end
                        default: begin
                            n_strobe = 1'b1;
                            n_ostat  = ole_pkg::STAT_OK;
                            n_oidx   = '0;
                            n_oval   = ole_pkg::VAL_W'(i_ram_rdata);
                            n_olast  = ((CW'(r_da) + CW'(1)) == r_count);
                            if (n_olast) begin
                                n_state = ole_pkg::S_IDLE;
                            end
                        end
                    endcase
                end else if (r_rem == '0) begin
                    n_state = ole_pkg::S_IDLE;
                    n_oidx  = '0;
                    n_oval  = '0;
                    n_olast = 1'b1;
                    n_ostat = ole_pkg::STAT_OK;
                    n_strobe = 1'b1;
                    case (r_mode)
                        ole_pkg::M_SHUP: begin
                            o_ram_req.we    = 1'b1;
                            o_ram_req.waddr = r_pos[IW-1:0];
                            o_ram_req.wdata = r_val;
                            n_count = r_count + CW'(1);
                        end
                        ole_pkg::M_SHDN: begin
                            n_count = r_count - CW'(1);
                        end
                        ole_pkg::M_FIND: begin
                            if (r_found && r_rm) begin
                                // remove: erase the match in a second pass
                                n_strobe = 1'b0;
                                n_state  = ole_pkg::S_WALK;
                                n_mode   = ole_pkg::M_SHDN;
                                n_ra     = r_fidx + IW'(1);
                                n_rem    = r_count - CW'(1) - CW'(r_fidx);
                            end else if (r_found) begin
                                n_oidx = ole_pkg::IDX_W'(r_fidx);
                            end else begin
                                n_ostat = ole_pkg::STAT_NOTFOUND;
                            end
                        end
                        ole_pkg::M_COMPACT: begin
                            n_count = r_wp;
                            if (r_wp == r_count) begin
                                n_ostat = ole_pkg::STAT_NOTFOUND;
                            end
                        end
                        default: begin
                            n_strobe = 1'b0;
                        end
                    endcase
                end
            end

            default: begin
                n_state = ole_pkg::S_IDLE;
            end
        endcase
    end

    assign busy          = (r_state != ole_pkg::S_IDLE);
    assign o_strobe      = r_strobe;
    assign o_status      = r_ostat;
    assign o_found_index = r_oidx;
    assign o_entry_value = r_oval;
    assign o_entry_count = ole_pkg::CNT_W'(r_count);
    assign o_last        = r_olast;

endmodule

`default_nettype wire

// ===== sim/tb_top.sv =====
`timescale 1ns / 100ps
// tb_top: self-checking bench for ordered_list_engine_top. Sends list commands
// through start/busy, tracks the expected list contents in-bench and checks each
// strobed result in order. Depends on ole_pkg and the RTL under src.
module tb_top;

    localparam logic [ole_pkg::CMD_W-1:0] CMD_RSVD_LO = 4'd10;
    localparam logic [ole_pkg::CMD_W-1:0] CMD_RSVD_HI = 4'd15;
    localparam int RANDOM_ITEMS = 115;

    typedef struct {
        logic [ole_pkg::STAT_W-1:0] status;
        logic [ole_pkg::IDX_W-1:0]  found_idx;
        logic [ole_pkg::VAL_W-1:0]  word;
        logic [ole_pkg::CNT_W-1:0]  entry_cnt;
        logic                       last;
    } t_list_result;

    logic                       i_clk = 1'b0;
    logic                       i_rst_n = 1'b0;
    logic                       start = 1'b0;
    logic                       busy;
    logic [ole_pkg::CMD_W-1:0]  i_cmd = '0;
    logic [ole_pkg::VAL_W-1:0]  i_value = '0;
    logic [ole_pkg::POS_W-1:0]  i_position = '0;
    logic                       o_strobe;
    logic [ole_pkg::STAT_W-1:0] o_status;
    logic [ole_pkg::IDX_W-1:0]  o_found_index;
    logic [ole_pkg::VAL_W-1:0]  o_entry_value;
    logic [ole_pkg::CNT_W-1:0]  o_entry_count;
    logic                       o_last;

    bit                         idle_en = 1'b1;
    int                         mismatch_count = 0;
    logic [ole_pkg::VAL_W-1:0]  list_words [ole_pkg::DEPTH];
    int                         list_len = 0;
    t_list_result               expected_results [$];

    ordered_list_engine_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .start         (start),
        .busy          (busy),
        .i_cmd         (i_cmd),
        .i_value       (i_value),
        .i_position    (i_position),
        .o_strobe      (o_strobe),
        .o_status      (o_status),
        .o_found_index (o_found_index),
        .o_entry_value (o_entry_value),
        .o_entry_count (o_entry_count),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic int find_word(logic [ole_pkg::VAL_W-1:0] word);
        for (int i = 0; i < list_len; i++)
            if (list_words[i] == word) return i;
        return -1;
    endfunction

    function automatic void insert_entry(int pos, logic [ole_pkg::VAL_W-1:0] word);
        for (int i = list_len; i > pos; i--)
            list_words[i] = list_words[i-1];
        list_words[pos] = word;
        list_len++;
    endfunction

    function automatic void erase_entry(int pos);
        for (int i = pos; i + 1 < list_len; i++)
            list_words[i] = list_words[i+1];
        list_len--;
    endfunction

    function automatic void expect_one(logic [ole_pkg::STAT_W-1:0] status, int idx);
        t_list_result r;
        r.status    = status;
        r.found_idx = idx[ole_pkg::IDX_W-1:0];
        r.word      = '0;
        r.entry_cnt = list_len[ole_pkg::CNT_W-1:0];
        r.last      = 1'b1;
        expected_results.push_back(r);
    endfunction

    // updates the list image and queues what the command must give out
    function automatic void predict_list_cmd(logic [ole_pkg::CMD_W-1:0] code,
                                             logic [ole_pkg::VAL_W-1:0] word,
                                             logic [ole_pkg::POS_W-1:0] pos);
        int hit;
        int kept;
        t_list_result r;
        case (code) inside
            ole_pkg::CMD_PUSH_BACK, ole_pkg::CMD_PUSH_FRONT: begin
                if (list_len >= ole_pkg::DEPTH) begin
                    expect_one(ole_pkg::STAT_FULL, 0);
                end else begin
                    insert_entry((code == ole_pkg::CMD_PUSH_BACK) ? list_len : 0, word);
                    expect_one(ole_pkg::STAT_OK, 0);
                end
            end
            ole_pkg::CMD_POP_BACK: begin
                if (list_len == 0) begin
                    expect_one(ole_pkg::STAT_EMPTY, 0);
                end else begin
                    list_len--;
                    expect_one(ole_pkg::STAT_OK, 0);
                end
            end
            ole_pkg::CMD_POP_FRONT: begin
                if (list_len == 0) begin
                    expect_one(ole_pkg::STAT_EMPTY, 0);
                end else begin
                    erase_entry(0);
                    expect_one(ole_pkg::STAT_OK, 0);
                end
            end
            ole_pkg::CMD_FIND: begin
                hit = find_word(word);
                if (hit < 0) expect_one(ole_pkg::STAT_NOTFOUND, 0);
                else expect_one(ole_pkg::STAT_OK, hit);
            end
            ole_pkg::CMD_INSERT: begin
                if (int'(pos) > list_len) begin
                    expect_one(ole_pkg::STAT_BADPOS, 0);
                end else if (list_len >= ole_pkg::DEPTH) begin
                    expect_one(ole_pkg::STAT_FULL, 0);
                end else begin
                    insert_entry(int'(pos), word);
                    expect_one(ole_pkg::STAT_OK, 0);
                end
            end
            ole_pkg::CMD_ERASE: begin
                if (list_len == 0) begin
                    expect_one(ole_pkg::STAT_EMPTY, 0);
                end else if (int'(pos) >= list_len) begin
                    expect_one(ole_pkg::STAT_BADPOS, 0);
                end else begin
                    erase_entry(int'(pos));
                    expect_one(ole_pkg::STAT_OK, 0);
                end
            end
            ole_pkg::CMD_REMOVE: begin
                hit = find_word(word);
                if (list_len == 0) begin
                    expect_one(ole_pkg::STAT_EMPTY, 0);
                end else if (hit < 0) begin
                    expect_one(ole_pkg::STAT_NOTFOUND, 0);
                end else begin
                    erase_entry(hit);
                    expect_one(ole_pkg::STAT_OK, 0);
                end
            end
            ole_pkg::CMD_REMOVE_ALL: begin
                if (list_len == 0) begin
                    expect_one(ole_pkg::STAT_EMPTY, 0);
                end else begin
                    kept = 0;
                    for (int i = 0; i < list_len; i++)
                        if (list_words[i] != word) begin
                            list_words[kept] = list_words[i];
                            kept++;
                        end
                    hit = (kept == list_len);
                    list_len = kept;
                    expect_one(hit ? ole_pkg::STAT_NOTFOUND : ole_pkg::STAT_OK, 0);
                end
            end
            ole_pkg::CMD_DUMP: begin
                if (list_len == 0) begin
                    expect_one(ole_pkg::STAT_EMPTY, 0);
                end else begin
                    for (int i = 0; i < list_len; i++) begin
                        r.status    = ole_pkg::STAT_OK;
                        r.found_idx = '0;
                        r.word      = list_words[i];
                        r.entry_cnt = list_len[ole_pkg::CNT_W-1:0];
                        r.last      = (i == list_len - 1);
                        expected_results.push_back(r);
                    end
                end
            end
            default: ;
        endcase
    endfunction

    // start stays high across back-to-back items; it drops only for a gap
    task automatic send_item(logic [ole_pkg::CMD_W-1:0] code,
                             logic [ole_pkg::VAL_W-1:0] word,
                             logic [ole_pkg::POS_W-1:0] pos);
        if (idle_en && $urandom_range(99) < 38) begin
            start <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        start      <= 1'b1;
        i_cmd      <= code;
        i_value    <= word;
        i_position <= pos;
        @(posedge i_clk);
        while (busy) @(posedge i_clk);
        predict_list_cmd(code, word, pos);
    endtask

    function automatic void check_field(string name, logic [ole_pkg::VAL_W-1:0] want,
                                        logic [ole_pkg::VAL_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            mismatch_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_list_result exp_r;
        if (o_strobe === 1'b1) begin
            if (expected_results.size() == 0) begin
                $error("result with nothing expected: status %0d", o_status);
                mismatch_count++;
            end else begin
                exp_r = expected_results.pop_front();
                check_field("status", ole_pkg::VAL_W'(exp_r.status),
                            ole_pkg::VAL_W'(o_status));
                check_field("found_index", ole_pkg::VAL_W'(exp_r.found_idx),
                            ole_pkg::VAL_W'(o_found_index));
                check_field("entry_value", exp_r.word, o_entry_value);
                check_field("entry_count", ole_pkg::VAL_W'(exp_r.entry_cnt),
                            ole_pkg::VAL_W'(o_entry_count));
                check_field("last", ole_pkg::VAL_W'(exp_r.last), ole_pkg::VAL_W'(o_last));
            end
        end
    end

    task automatic test_empty_list();
        send_item(ole_pkg::CMD_DUMP, '0, '0);
        send_item(ole_pkg::CMD_POP_BACK, '0, '0);
        send_item(ole_pkg::CMD_POP_FRONT, '0, '0);
        send_item(ole_pkg::CMD_ERASE, '0, '0);
        send_item(ole_pkg::CMD_REMOVE, '0, '0);
        send_item(ole_pkg::CMD_REMOVE_ALL, '0, '0);
        send_item(ole_pkg::CMD_FIND, '0, '0);
    endtask

    task automatic test_edit_ops();
        send_item(ole_pkg::CMD_PUSH_BACK, 32'h7fff_ffff, '0);
        send_item(ole_pkg::CMD_PUSH_FRONT, 32'h8000_0000, '0);
        send_item(ole_pkg::CMD_INSERT, 32'hffff_ffff, 5'd1);
        send_item(ole_pkg::CMD_INSERT, 32'h1, 5'd4);
        send_item(ole_pkg::CMD_ERASE, '0, 5'd3);
        send_item(ole_pkg::CMD_ERASE, '0, 5'd31);
        send_item(ole_pkg::CMD_FIND, 32'hffff_ffff, '0);
        send_item(ole_pkg::CMD_FIND, '0, '0);
        send_item(ole_pkg::CMD_PUSH_BACK, 32'hffff_ffff, '0);
        send_item(ole_pkg::CMD_REMOVE_ALL, 32'h1, '0);
        send_item(ole_pkg::CMD_REMOVE_ALL, 32'hffff_ffff, '0);
        send_item(ole_pkg::CMD_REMOVE, 32'h1234, '0);
        send_item(ole_pkg::CMD_REMOVE, 32'h8000_0000, '0);
        send_item(ole_pkg::CMD_DUMP, '0, '0);
        send_item(CMD_RSVD_LO, 32'h5555_aaaa, 5'd2);
        send_item(CMD_RSVD_HI, 32'haaaa_5555, 5'd31);
        send_item(ole_pkg::CMD_ERASE, '0, 5'd0);
    endtask

    task automatic test_full_list();
        while (list_len < ole_pkg::DEPTH) send_item(ole_pkg::CMD_PUSH_BACK, $urandom(), '0);
        send_item(ole_pkg::CMD_PUSH_BACK, 32'h1, '0);
        send_item(ole_pkg::CMD_PUSH_FRONT, 32'h2, '0);
        send_item(ole_pkg::CMD_INSERT, 32'h3, 5'd16);
        send_item(ole_pkg::CMD_INSERT, 32'h4, 5'd17);
        send_item(ole_pkg::CMD_FIND, list_words[ole_pkg::DEPTH-1], '0);
        send_item(ole_pkg::CMD_DUMP, '0, '0);
        send_item(ole_pkg::CMD_ERASE, '0, 5'd15);
    endtask

    // swings the list between empty and full; a small value pool makes hits common
    task automatic test_random_traffic();
        logic [ole_pkg::VAL_W-1:0] pool [4];
        logic [ole_pkg::VAL_W-1:0] word;
        logic [ole_pkg::POS_W-1:0] pos;
        logic [ole_pkg::CMD_W-1:0] code;
        bit grow;
        int roll;
        int sent;
        for (int k = 0; k < 4; k++) pool[k] = $urandom();
        grow = 1'b1;
        sent = 0;
        while (sent < RANDOM_ITEMS) begin
            idle_en = !(sent >= 40 && sent < 80);
            if (list_len >= ole_pkg::DEPTH) grow = 1'b0;
            else if (list_len == 0) grow = 1'b1;
            else if ($urandom_range(99) < 4) grow = !grow;
            word = ($urandom_range(99) < 60) ? pool[$urandom_range(3)] : $urandom();
            pos = ($urandom_range(99) < 85) ? ole_pkg::POS_W'($urandom_range(list_len))
                                            : ole_pkg::POS_W'($urandom_range(31));
            roll = $urandom_range(99);
            if (roll < 3) begin
                code = ole_pkg::CMD_W'($urandom_range(CMD_RSVD_LO, CMD_RSVD_HI));
            end else if (roll < 9) begin
                code = ole_pkg::CMD_DUMP;
            end else if (roll < 19) begin
                code = ole_pkg::CMD_FIND;
            end else if (grow) begin
                roll = $urandom_range(99);
                if (roll < 35) code = ole_pkg::CMD_PUSH_BACK;
                else if (roll < 55) code = ole_pkg::CMD_PUSH_FRONT;
                else if (roll < 80) code = ole_pkg::CMD_INSERT;
                else if (roll < 88) code = ole_pkg::CMD_ERASE;
                else if (roll < 94) code = ole_pkg::CMD_REMOVE;
                else code = ole_pkg::CMD_POP_FRONT;
            end else begin
                roll = $urandom_range(99);
                if (roll < 20) code = ole_pkg::CMD_POP_BACK;
                else if (roll < 38) code = ole_pkg::CMD_POP_FRONT;
                else if (roll < 60) code = ole_pkg::CMD_ERASE;
                else if (roll < 80) code = ole_pkg::CMD_REMOVE;
                else if (roll < 88) code = ole_pkg::CMD_REMOVE_ALL;
                else if (roll < 94) code = ole_pkg::CMD_PUSH_BACK;
                else code = ole_pkg::CMD_INSERT;
            end
            send_item(code, word, pos);
            if (code < CMD_RSVD_LO) sent++;
        end
        idle_en = 1'b1;
    endtask

    task automatic drain_results();
        start <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    initial begin
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_empty_list();
        test_edit_ops();
        test_full_list();
        test_random_traffic();
        drain_results();
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("end of test: mismatches");
        $finish;
    end

endmodule

// ===== ordered_list_engine_top.f =====
src/ole_pkg.sv
src/ole_ram.sv
src/ole_ctrl.sv
src/ordered_list_engine_top.sv
sim/tb_top.sv
